/* rtl/nsbp_pkg.sv */
// Shared types and constants for the number serializer and bit packer.
package nsbp_pkg;

	localparam int BYTE_W      = 8;
	localparam int VALUE_W     = 32;
	localparam int COUNT_W     = 6;
	localparam int MODE_W      = 3;
	localparam int MAX_BYTES   = 4;
	localparam int MAX_BITS    = 32;
	localparam int JOB_BYTES   = 5;
	localparam int JOB_N_W     = 3;
	localparam int PEND_W      = 7;
	localparam int PCNT_W      = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [MODE_W-1:0] MODE_LE    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_BE    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PDP   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_BITS  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FLUSH = 3'd4;

	// One classified item: the bytes to send, how many of them, and the error mark.
	typedef struct packed {
		logic [JOB_BYTES-1:0][BYTE_W-1:0] bytes;
		logic [JOB_N_W-1:0]               n;
		logic                             err;
	} nsbp_job_t;

endpackage

/* rtl/nsbp_front.sv */
// Front end: accepts items, tracks the pending bits and builds a byte job per item.
module nsbp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [nsbp_pkg::MODE_W-1:0]   mode,
	input  logic [nsbp_pkg::VALUE_W-1:0]  value,
	input  logic [nsbp_pkg::COUNT_W-1:0]  count,
	input  logic                          queue_full,
	output logic                          push,
	output nsbp_pkg::nsbp_job_t           push_job
);
	import nsbp_pkg::*;

	logic [PEND_W-1:0]                pbits_q;
	logic [PCNT_W-1:0]                pcnt_q;
	logic [PEND_W-1:0]                pbits_d;
	logic [PCNT_W-1:0]                pcnt_d;
	logic                             accept;
	logic                             err;
	logic                             flush_en;
	logic [MAX_BYTES-1:0][BYTE_W-1:0] d;
	logic [JOB_N_W-1:0]               dn;
	logic [MAX_BYTES-1:0][BYTE_W-1:0] vb;
	logic [VALUE_W-1:0]               vmask;
	logic [VALUE_W+PEND_W-1:0]        acc;
	logic [COUNT_W-1:0]               total;
	logic [2:0]                       nb;
	logic [1:0]                       bidx;
	logic [PEND_W+1:0]                rem_mask;
	nsbp_job_t                        job;

	assign item_stall = queue_full;
	assign accept     = item_valid && !queue_full;
	assign vb         = value;

	assign vmask    = (count >= COUNT_W'(MAX_BITS)) ? '1
	                  : VALUE_W'((33'd1 << count) - 33'd1);
	assign acc      = (VALUE_W+PEND_W)'(pbits_q)
	                  | ((VALUE_W+PEND_W)'(value & vmask) << pcnt_q);
	assign total    = COUNT_W'(pcnt_q) + count;
	assign nb       = total[5:3];
	assign rem_mask = (PEND_W+2)'((9'd1 << total[2:0]) - 9'd1);

	always_comb begin
		err      = 1'b0;
		flush_en = 1'b0;
		d        = '0;
		dn       = '0;
		bidx     = '0;
		pbits_d  = pbits_q;
		pcnt_d   = pcnt_q;
		if (mode <= MODE_PDP) begin
			err = (count > COUNT_W'(MAX_BYTES));
		end else if (mode == MODE_BITS) begin
			err = (count > COUNT_W'(MAX_BITS));
		end
		if (!err) begin
			unique case (mode)
				MODE_LE: begin
					flush_en = 1'b1;
					d        = vb;
					dn       = JOB_N_W'(count);
				end
				MODE_BE: begin
					flush_en = 1'b1;
					dn       = JOB_N_W'(count);
					for (int k = 0; k < MAX_BYTES; k++) begin
						bidx = 2'(count - COUNT_W'(k + 1));
						if (COUNT_W'(k) < count) begin
							d[k] = vb[bidx];
						end
					end
				end
				MODE_PDP: begin
					// The value sits at the top of the word, so the sent bytes are the low ones
					// of the value; four bytes go in the order third, fourth, first, second.
					flush_en = 1'b1;
					dn       = JOB_N_W'(count);
					unique case (count[2:0])
						3'd1:    d = {24'd0, vb[0]};
						3'd2:    d = {16'd0, vb[1], vb[0]};
						3'd3:    d = {8'd0, vb[0], vb[2], vb[1]};
						3'd4:    d = {vb[1], vb[0], vb[3], vb[2]};
						default: d = '0;
					endcase
				end
				MODE_BITS: begin
					dn = nb;
					for (int k = 0; k < MAX_BYTES; k++) begin
						d[k] = acc[k*BYTE_W +: BYTE_W];
					end
					pcnt_d  = total[2:0];
					pbits_d = PEND_W'(acc >> {nb, 3'b000}) & PEND_W'(rem_mask);
				end
				MODE_FLUSH: begin
					flush_en = 1'b1;
				end
				default: begin
					dn = '0;
				end
			endcase
			if (flush_en) begin
				pbits_d = '0;
				pcnt_d  = '0;
			end
		end
	end

	always_comb begin
		job = '0;
		if (err) begin
			job.n   = JOB_N_W'(1);
			job.err = 1'b1;
		end else if (flush_en && pcnt_q != '0) begin
			job.bytes = {d, BYTE_W'(pbits_q)};
			job.n     = dn + JOB_N_W'(1);
		end else begin
			job.bytes = {8'd0, d};
			job.n     = dn;
		end
	end

	assign push     = accept && (job.n != '0);
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pbits_q <= '0;
			pcnt_q  <= '0;
		end else if (accept) begin
			pbits_q <= pbits_d;
			pcnt_q  <= pcnt_d;
		end
	end

`ifndef SYNTHESIS
	a_pending_masked: assert property (@(posedge clk) disable iff (!arst_n)
		(pbits_q >> pcnt_q) == '0)
		else $error("pending bits set above the pending count");
`endif

endmodule

/* rtl/nsbp_queue.sv */
// Two-entry job queue between the front end and the byte sender.
module nsbp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  nsbp_pkg::nsbp_job_t push_job,
	output logic                full,
	output logic                head_valid,
	output nsbp_pkg::nsbp_job_t head_job,
	input  logic                pop
);
	import nsbp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	nsbp_job_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     cnt_q;

	assign full       = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job written into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job taken from an empty queue");
`endif

endmodule

/* rtl/nsbp_back.sv */
// Byte sender: walks the head job byte by byte into the output register.
module nsbp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  nsbp_pkg::nsbp_job_t          head_job,
	output logic                         pop,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [nsbp_pkg::BYTE_W-1:0]  out_byte,
	output logic                         last,
	output logic                         error
);
	import nsbp_pkg::*;

	logic [JOB_N_W-1:0] idx_q;
	logic               res_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               last_q;
	logic               error_q;
	logic               load;
	logic               is_last;

	assign load    = head_valid && (!res_valid_q || !result_stall);
	assign is_last = (idx_q == head_job.n - JOB_N_W'(1));
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + JOB_N_W'(1);
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head_job.bytes[idx_q];
			last_q     <= is_last;
			error_q    <= head_job.err;
		end
	end

	assign result_valid = res_valid_q;
	assign out_byte     = out_byte_q;
	assign last         = last_q;
	assign error        = error_q;

`ifndef SYNTHESIS
	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q < head_job.n))
		else $error("byte index beyond the length of the head job");
`endif

endmodule

/* rtl/number_serializer_bit_packer_unit.sv */
// Top level of the number serializer and bit packer.
//
//   channel  signals                        direction  contents
//   item     item_valid / item_stall        in         mode, value, count
//   result   result_valid / result_stall    out        out_byte, last, error
//
// Each item is classified in the cycle it is accepted and yields up to five bytes,
// sent one per cycle by the byte sender while the result is not stalled; items
// without results are not queued.
// A two-entry job queue lets the front end keep taking items while bytes are sent.
// Reset clears the pending bits, the queue and the result valid flag.
// A stalled result holds in the output register, and a full queue stalls new items.
module number_serializer_bit_packer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [nsbp_pkg::MODE_W-1:0]   mode,
	input  logic [nsbp_pkg::VALUE_W-1:0]  value,
	input  logic [nsbp_pkg::COUNT_W-1:0]  count,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [nsbp_pkg::BYTE_W-1:0]   out_byte,
	output logic                          last,
	output logic                          error
);
	import nsbp_pkg::*;

	logic      push;
	logic      pop;
	logic      queue_full;
	logic      head_valid;
	nsbp_job_t push_job;
	nsbp_job_t head_job;

	nsbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.value      (value),
		.count      (count),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	nsbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop)
	);

	nsbp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.last         (last),
		.error        (error)
	);

endmodule
